// ===== src/epwr_pkg.sv =====
package epwr_pkg;

  localparam int unsigned CNT_W   = 16;
  localparam int unsigned OVF_W   = 6;
  localparam int unsigned TICKS_W = 22;
  localparam int unsigned SCALE_W = 10;
  localparam int unsigned PROD_W  = 32;
  localparam int unsigned DIST_W  = 23;

  localparam logic [OVF_W-1:0]   OVF_LIMIT   = 6'h3F;
  localparam logic [CNT_W-1:0]   FULL_COUNT  = 16'hFFFF;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd170;

  // Reciprocal of 1000 scaled by 2**38; exact for every 32-bit dividend.
  localparam logic [28:0]        RECIP_1000  = 29'h10624DD3;
  localparam int unsigned        RECIP_SHIFT = 38;
  localparam logic [PROD_W-1:0]  SCALE_DIV   = 32'd1000;

  typedef struct packed {
    logic             kind;
    logic             overflow_event;
    logic             capture_event;
    logic [CNT_W-1:0] capture_value;
  } in_word_t;

  typedef struct packed {
    logic              distance_valid;
    logic [DIST_W-1:0] distance_mm;
    logic              clear_counter;
    logic              capture_falling;
    logic              trigger_pulse;
  } out_word_t;

  // One classified word handed from the front end to the arithmetic back end.
  typedef struct packed {
    logic               dist_valid;
    logic [TICKS_W-1:0] ticks;
    logic               clr;
    logic               falling;
    logic               trig;
  } job_t;

  typedef struct packed {
    logic measure_done;
    logic high_phase;
  } front_status_t;

endpackage

// ===== src/epwr_front.sv =====
module epwr_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  epwr_pkg::in_word_t      in_data,
  output epwr_pkg::job_t          job,
  output epwr_pkg::front_status_t status
);
  import epwr_pkg::*;

  logic             measure_done_r, measure_done_nxt;
  logic             high_phase_r, high_phase_nxt;
  logic             falling_r, falling_nxt;
  logic [OVF_W-1:0] ovf_count_r, ovf_count_nxt;
  logic [CNT_W-1:0] cap_count_r, cap_count_nxt;
  logic             clr;
  logic             dist_valid;

  always_comb begin
    measure_done_nxt = measure_done_r;
    high_phase_nxt   = high_phase_r;
    falling_nxt      = falling_r;
    ovf_count_nxt    = ovf_count_r;
    cap_count_nxt    = cap_count_r;
    clr              = 1'b0;
    dist_valid       = 1'b0;
    if (in_data.kind) begin
      if (measure_done_r) begin
        dist_valid       = 1'b1;
        measure_done_nxt = 1'b0;
        high_phase_nxt   = 1'b0;
        ovf_count_nxt    = '0;
        cap_count_nxt    = '0;
      end
    end else if (!measure_done_r) begin
      // The overflow is taken first, so a capture in the same word still wins.
      if (in_data.overflow_event && high_phase_r) begin
        if (ovf_count_r == OVF_LIMIT) begin
          measure_done_nxt = 1'b1;
          cap_count_nxt    = FULL_COUNT;
        end else begin
          ovf_count_nxt = ovf_count_r + 1'b1;
        end
      end
      if (in_data.capture_event) begin
        if (high_phase_r) begin
          measure_done_nxt = 1'b1;
          cap_count_nxt    = in_data.capture_value;
          falling_nxt      = 1'b0;
        end else begin
          measure_done_nxt = 1'b0;
          ovf_count_nxt    = '0;
          cap_count_nxt    = '0;
          high_phase_nxt   = 1'b1;
          clr              = 1'b1;
          falling_nxt      = 1'b1;
        end
      end
    end
  end

  always_comb begin
    job.dist_valid = dist_valid;
    // overflows * 65535 is overflows * 2**16 minus overflows.
    job.ticks      = dist_valid
                     ? ({ovf_count_r, {CNT_W{1'b0}}} - {{CNT_W{1'b0}}, ovf_count_r}
                        + {{OVF_W{1'b0}}, cap_count_r})
                     : '0;
    job.clr        = clr;
    job.falling    = falling_nxt;
    job.trig       = in_data.kind;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      measure_done_r <= 1'b0;
      high_phase_r   <= 1'b0;
      falling_r      <= 1'b0;
      ovf_count_r    <= '0;
      cap_count_r    <= '0;
    end else if (accept) begin
      measure_done_r <= measure_done_nxt;
      high_phase_r   <= high_phase_nxt;
      falling_r      <= falling_nxt;
      ovf_count_r    <= ovf_count_nxt;
      cap_count_r    <= cap_count_nxt;
    end
  end

  assign status.measure_done = measure_done_r;
  assign status.high_phase   = high_phase_r;

endmodule

// ===== src/epwr_queue.sv =====
module epwr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  epwr_pkg::job_t push_data,
  input  logic           pop,
  output epwr_pkg::job_t pop_data,
  output logic           full,
  output logic           empty
);
  import epwr_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== src/epwr_back.sv =====
module epwr_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [9:0]                cfg_wdata,
  input  logic                      q_empty,
  input  epwr_pkg::job_t            q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output epwr_pkg::out_word_t       out_data
);
  import epwr_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MUL  = 4'b0010,
    B_RCP  = 4'b0100,
    B_FIX  = 4'b1000
  } back_state_t;

  back_state_t        state_r, state_nxt;
  logic [SCALE_W-1:0] scale_r;
  job_t               job_r;
  logic [PROD_W-1:0]  prod_r;
  logic [DIST_W-1:0]  quot_r;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_data_r;
  logic [60:0]        recip_prod;
  logic [PROD_W-1:0]  quot_times_div;
  logic [PROD_W-1:0]  remainder;
  logic [DIST_W-1:0]  quot_fixed;
  logic               load_out;

  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign load_out = (state_r == B_FIX) && (!out_valid_r || out_ready);

  assign recip_prod     = {29'b0, prod_r} * {32'b0, RECIP_1000};
  // q * 1000 as q * 1024 - q * 16 - q * 8.
  assign quot_times_div = PROD_W'({quot_r, 10'b0})
                          - PROD_W'({quot_r, 4'b0})
                          - PROD_W'({quot_r, 3'b0});
  assign remainder      = prod_r - quot_times_div;
  assign quot_fixed     = (remainder >= SCALE_DIV) ? quot_r + 1'b1 : quot_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: if (!q_empty) state_nxt = B_MUL;
      B_MUL:  state_nxt = B_RCP;
      B_RCP:  state_nxt = B_FIX;
      B_FIX:  if (load_out) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_data;
    end
    if (state_r == B_MUL) begin
      prod_r <= PROD_W'({{(PROD_W-TICKS_W){1'b0}}, job_r.ticks}
                        * {{(PROD_W-SCALE_W){1'b0}}, scale_r});
    end
    if (state_r == B_RCP) begin
      quot_r <= recip_prod[RECIP_SHIFT +: DIST_W];
    end
    if (load_out) begin
      out_data_r.distance_valid  <= job_r.dist_valid;
      out_data_r.distance_mm     <= quot_fixed;
      out_data_r.clear_counter   <= job_r.clr;
      out_data_r.capture_falling <= job_r.falling;
      out_data_r.trigger_pulse   <= job_r.trig;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      scale_r     <= SCALE_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        scale_r <= cfg_wdata;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/echo_pulse_width_ranger.sv =====
// Echo pulse width ranger: measures an ultrasonic echo with a capture timer.
// The in_ channel takes one word per timer event (overflow and capture flags
// with the captured count) or per distance read request. Every accepted word
// yields exactly one word on the out_ channel, in order: the distance in mm
// when a read finds a finished measurement, the counter clear request, the
// capture polarity and the trigger pulse.
// The front end updates the measurement state in the cycle a word is taken
// and queues it; the back end runs each queued word through a sequencer of
// four steps (queue pop, tick-by-scale multiply, reciprocal multiply for the
// divide by 1000, remainder correction into the output register), and it
// takes a queued word only once the previous one has left the sequencer.
// The front end keeps accepting until the queue of QUEUE_DEPTH words is
// full; in_ready drops when words arrive faster than the back end finishes
// them or when the receiver stalls, since a stalled result holds in the
// output register and the back end waits behind it.
// cfg_we writes the scale (thousandths of a mm per tick);
// write it only while no word is in flight.
// Synchronous reset clears the measurement state, empties the queue and
// restores the scale to 170; the block is ready in the next cycle.
module echo_pulse_width_ranger #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  epwr_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output epwr_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic [9:0]          cfg_wdata
);
  import epwr_pkg::*;

  logic          accept;
  job_t          push_job;
  job_t          pop_job;
  logic          q_full, q_empty, q_pop;
  front_status_t front_status;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  epwr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .job     (push_job),
    .status  (front_status)
  );

  epwr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (push_job),
    .pop       (q_pop),
    .pop_data  (pop_job),
    .full      (q_full),
    .empty     (q_empty)
  );

  epwr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_empty),
    .q_data    (pop_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A finished measurement can only exist inside a high phase.
  a_done_in_high: assert property (@(posedge clk) disable iff (!rst_n)
    front_status.measure_done |-> front_status.high_phase)
    else $error("measurement done outside the high phase");

  // A distance is reported only on a read, which always triggers.
  a_dist_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.distance_valid |-> out_data.trigger_pulse)
    else $error("distance reported without a read");

  a_dist_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.distance_valid |-> out_data.distance_mm == '0)
    else $error("nonzero distance without distance_valid");

  // Clearing the counter arms the falling-edge capture in the same word.
  a_clr_falling: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.clear_counter |-> out_data.capture_falling)
    else $error("counter clear without falling-edge capture");

endmodule

// ===== verif/tb_echo_pulse_width_ranger.sv =====
`timescale 1ns / 1ps

module tb_echo_pulse_width_ranger;
  import epwr_pkg::*;

  localparam logic KIND_TIMER = 1'b0;
  localparam logic KIND_READ  = 1'b1;
  localparam int   IDLE_PCT     = 28;
  localparam int   DRAIN_CYCLES = 8;
  localparam int   TARGET_WORDS = 750;
  localparam int   TIMEOUT_NS   = 2_000_000;
  localparam int   IN_W         = $bits(in_word_t);

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_word_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_word_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [SCALE_W-1:0]  cfg_wdata = '0;

  // Shadow copy of the measurement state and the scale register.
  logic                m_done    = 1'b0;
  logic                m_high    = 1'b0;
  logic [OVF_W-1:0]    m_ovf     = '0;
  logic [CNT_W-1:0]    m_cnt     = '0;
  logic                m_falling = 1'b0;
  logic [SCALE_W-1:0]  m_scale   = SCALE_RESET;

  out_word_t pending_echo_results[$];
  bit        idle_on = 1'b1;
  int        n_errors = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  int        n_distances = 0;
  int        n_forced = 0;
  int        n_scale_writes = 0;

  echo_pulse_width_ranger u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

  // Advances the shadow state by one accepted word and returns the result it causes.
  function automatic out_word_t ranger_result(input in_word_t w);
    out_word_t       r;
    longint unsigned ticks;
    longint unsigned prod;
    r = '0;
    if (w.kind == KIND_READ) begin
      r.trigger_pulse = 1'b1;
      if (m_done) begin
        ticks = 64'(m_ovf) * 64'd65535 + 64'(m_cnt);
        prod = ticks * 64'(m_scale);
        r.distance_valid = 1'b1;
        r.distance_mm = DIST_W'(prod / 64'd1000);
        m_done = 1'b0;
        m_high = 1'b0;
        m_ovf = '0;
        m_cnt = '0;
        n_distances++;
      end
    end else if (!m_done) begin
      if (w.overflow_event && m_high) begin
        if (m_ovf == OVF_LIMIT) begin
          m_done = 1'b1;
          m_cnt = FULL_COUNT;
          n_forced++;
        end else begin
          m_ovf = m_ovf + 1'b1;
        end
      end
      if (w.capture_event) begin
        if (m_high) begin
          m_done = 1'b1;
          m_cnt = w.capture_value;
          m_falling = 1'b0;
        end else begin
          m_ovf = '0;
          m_cnt = '0;
          m_high = 1'b1;
          m_falling = 1'b1;
          r.clear_counter = 1'b1;
        end
      end
    end
    r.capture_falling = m_falling;
    return r;
  endfunction

  // Result side: random back-pressure and in-order comparison.
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_checked++;
        if (pending_echo_results.size() == 0) begin
          $error("unexpected result word %h", out_data);
          n_errors++;
        end else begin
          exp_w = pending_echo_results.pop_front();
          if (out_data.distance_valid !== exp_w.distance_valid) begin
            $error("distance_valid: expected %0d, got %0d",
                   exp_w.distance_valid, out_data.distance_valid);
            n_errors++;
          end
          if (out_data.distance_mm !== exp_w.distance_mm) begin
            $error("distance_mm: expected %0d, got %0d",
                   exp_w.distance_mm, out_data.distance_mm);
            n_errors++;
          end
          if (out_data.clear_counter !== exp_w.clear_counter) begin
            $error("clear_counter: expected %0d, got %0d",
                   exp_w.clear_counter, out_data.clear_counter);
            n_errors++;
          end
          if (out_data.capture_falling !== exp_w.capture_falling) begin
            $error("capture_falling: expected %0d, got %0d",
                   exp_w.capture_falling, out_data.capture_falling);
            n_errors++;
          end
          if (out_data.trigger_pulse !== exp_w.trigger_pulse) begin
            $error("trigger_pulse: expected %0d, got %0d",
                   exp_w.trigger_pulse, out_data.trigger_pulse);
            n_errors++;
          end
        end
      end
      out_ready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Valid is left high after acceptance so that back-to-back words need no re-raise.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = 0;
    if (idle_on) begin
      while ($urandom_range(0, 99) < IDLE_PCT) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    pending_echo_results.push_back(ranger_result(w));
    n_sent++;
  endtask

  task automatic timer_ev(input logic ovf, input logic cap, input logic [CNT_W-1:0] val);
    in_word_t w;
    w.kind = KIND_TIMER;
    w.overflow_event = ovf;
    w.capture_event = cap;
    w.capture_value = val;
    send_word(w);
  endtask

  // The other fields of a read are don't-care, so they carry random junk.
  task automatic read_req();
    in_word_t w;
    w.kind = KIND_READ;
    w.overflow_event = 1'($urandom);
    w.capture_event = 1'($urandom);
    w.capture_value = CNT_W'($urandom);
    send_word(w);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_echo_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    m_scale = v;
    n_scale_writes++;
  endtask

  task automatic test_reads_without_echo();
    read_req();
    timer_ev(1'b1, 1'b0, 16'hFFFF);
    read_req();
  endtask

  task automatic test_short_echo();
    timer_ev(1'b0, 1'b1, 16'hFFFF);
    timer_ev(1'b1, 1'b0, 16'h5A5A);
    timer_ev(1'b0, 1'b1, 16'h0000);
    // Measurement is complete: this event must leave it untouched.
    timer_ev(1'b1, 1'b1, 16'h1234);
    read_req();
    read_req();
    timer_ev(1'b1, 1'b1, 16'h0001);
    timer_ev(1'b0, 1'b1, 16'hFFFF);
    read_req();
  endtask

  task automatic test_overflow_limit();
    write_scale(10'd1023);
    // Limit overflow and capture in one event: the capture value wins.
    timer_ev(1'b0, 1'b1, CNT_W'($urandom));
    repeat (63) timer_ev(1'b1, 1'b0, CNT_W'($urandom));
    timer_ev(1'b1, 1'b1, 16'h2468);
    read_req();
    // Pure overflow limit, then a capture that must be ignored.
    timer_ev(1'b0, 1'b1, CNT_W'($urandom));
    repeat (64) timer_ev(1'b1, 1'b0, CNT_W'($urandom));
    timer_ev(1'b0, 1'b1, CNT_W'($urandom));
    read_req();
    // Polarity is still falling, yet the next capture starts a new echo.
    timer_ev(1'b0, 1'b1, CNT_W'($urandom));
    timer_ev(1'b0, 1'b1, CNT_W'($urandom));
    read_req();
  endtask

  task automatic test_scale_settings();
    logic [SCALE_W-1:0] scales[5];
    scales[0] = 10'd0;
    scales[1] = 10'd1;
    scales[2] = 10'd1023;
    scales[3] = SCALE_W'($urandom);
    scales[4] = SCALE_RESET;
    foreach (scales[i]) begin
      write_scale(scales[i]);
      timer_ev(1'b0, 1'b1, CNT_W'($urandom));
      timer_ev(1'b1, 1'b0, CNT_W'($urandom));
      timer_ev(1'b1, 1'b1, CNT_W'($urandom));
      read_req();
    end
  endtask

  task automatic random_echo();
    int n_ovf;
    timer_ev(1'($urandom), 1'b1, CNT_W'($urandom));
    n_ovf = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 4);
    repeat (n_ovf) begin
      if ($urandom_range(0, 9) == 0) read_req();
      else timer_ev(1'b1, 1'b0, CNT_W'($urandom));
    end
    timer_ev($urandom_range(0, 3) == 0, 1'b1, CNT_W'($urandom));
    repeat ($urandom_range(0, 2)) timer_ev(1'($urandom), 1'($urandom), CNT_W'($urandom));
    read_req();
  endtask

  task automatic test_random_traffic();
    int       start;
    int       n_echoes;
    in_word_t w;
    start = n_sent;
    n_echoes = 0;
    while (n_sent < TARGET_WORDS) begin
      // A stretch with no idling on either side.
      idle_on = !((n_sent - start) >= 200 && (n_sent - start) < 350);
      if ($urandom_range(0, 4) != 0) begin
        random_echo();
        n_echoes++;
        if (n_echoes % 12 == 0) begin
          case ($urandom_range(0, 3))
            0: write_scale(10'd0);
            1: write_scale(10'd1023);
            default: write_scale(SCALE_W'($urandom));
          endcase
        end
      end else begin
        repeat ($urandom_range(1, 3)) begin
          w = IN_W'($urandom);
          send_word(w);
        end
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reads_without_echo();
    test_short_echo();
    test_overflow_limit();
    test_scale_settings();
    test_random_traffic();
    wait_idle();
    $display("Sent %0d words and checked %0d results, %0d of them distances.",
             n_sent, n_checked, n_distances);
    $display("Overflow-limit completions: %0d; scale writes: %0d.",
             n_forced, n_scale_writes);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
